### design/assert_macros.svh
// Assertion macros used by the cipher core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Implication: antecedent at one edge, consequent at the next.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### design/lrsc_pkg.sv
// Package: widths, ASCII constants, sequencer states and case folding for the cipher core.
package lrsc_pkg;

   localparam int LETTER_COUNT_DEF = 26;
   localparam int CHAR_W           = 8;
   localparam int RND_W            = 16;
   localparam int LETTER_W         = 5;

   localparam logic [CHAR_W-1:0] CHAR_A  = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_Z  = 8'h5A;
   localparam logic [CHAR_W-1:0] CHAR_LA = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LZ = 8'h7A;
   localparam logic [CHAR_W-1:0] CASE_OFFSET = CHAR_LA - CHAR_A;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_DIVIDE,
      ST_SELECT,
      ST_SHIFT,
      ST_REPLY
   } state_type;

   function automatic logic [CHAR_W-1:0] fold_upper(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] r;
      r = c;
      if (c >= CHAR_LA && c <= CHAR_LZ) begin
         r = c - CASE_OFFSET;
      end
      return r;
   endfunction

endpackage

### design/lazy_random_substitution_cipher_core.sv
// Top level: lazy random substitution cipher with an iterative modulo and pool compaction.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------------
//  req     | in        | req_valid/req_stall | req_in_char[7:0], req_random_value[15:0]
//  rsp     | out       | rsp_valid/rsp_stall | rsp_out_char[7:0]
//
// Steps per beat: non-letters and already mapped letters go through accept, lookup and
//   reply. A new letter goes through accept, lookup, the bit-serial remainder of
//   random_value by pool_count, select, the one-entry-per-cycle pool compaction and
//   reply.
// Reset (synchronous, active high) clears all map valid bits, reloads the pool with A to Z
//   and the pool count with LETTER_COUNT.
// The request side is stalled whenever the sequencer is not idle. A finished result sits
//   in the output register while rsp_stall is high; the next beat is still accepted then,
//   and its result waits in the reply state until the output register frees up.
module lazy_random_substitution_cipher_core #(
   parameter int LETTER_COUNT = lrsc_pkg::LETTER_COUNT_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [lrsc_pkg::CHAR_W-1:0]  req_in_char,
   input  logic [lrsc_pkg::RND_W-1:0]   req_random_value,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [lrsc_pkg::CHAR_W-1:0]  rsp_out_char
);
   import lrsc_pkg::*;

   `include "assert_macros.svh"

   localparam int IDX_W     = $clog2(LETTER_COUNT);      // pool / map index
   localparam int CNT_W     = $clog2(LETTER_COUNT + 1);  // pool count, remainder
   localparam int BIT_CNT_W = $clog2(RND_W);

   // ---------------------------------------------------------------- state
   state_type                state_ff, state_in;
   logic [CHAR_W-1:0]        char_ff, char_in;        // folded input byte
   logic [RND_W-1:0]         rnd_ff, rnd_in;          // dividend, shifted out MSB first
   logic [CNT_W-1:0]         rem_ff, rem_in;          // partial remainder
   logic [BIT_CNT_W-1:0]     bit_cnt_ff, bit_cnt_in;
   logic [CNT_W-1:0]         k_ff, k_in;              // compaction write pointer
   logic [CHAR_W-1:0]        res_ff, res_in;          // result waiting for the output reg
   logic [CNT_W-1:0]         count_ff, count_in;      // live pool entries
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]        rsp_char_ff, rsp_char_in;

   // letter map: valid bits reset-cleared, cipher index payload unreset
   logic [LETTER_COUNT-1:0]  map_valid_ff;
   logic [LETTER_W-1:0]      map_idx_ff [LETTER_COUNT];
   // pool of unused cipher letters
   logic [LETTER_W-1:0]      pool_ff [LETTER_COUNT];

   // write strobes computed by the sequencer
   logic                     map_we;
   logic                     pool_we;
   logic [IDX_W-1:0]         pool_wa;
   logic [IDX_W-1:0]         pool_ra;
   logic [LETTER_W-1:0]      pool_rd;

   // ---------------------------------------------------------------- datapath helpers
   logic [CHAR_W-1:0]        letter_off;
   logic [IDX_W-1:0]         letter_idx;
   logic                     is_letter;
   logic [CNT_W:0]           trial;
   logic                     trial_ge;
   logic [CNT_W-1:0]         k_next;
   logic                     out_free;

   assign letter_off = char_ff - CHAR_A;
   assign letter_idx = letter_off[IDX_W-1:0];
   assign is_letter  = (char_ff >= CHAR_A) && (char_ff <= CHAR_Z)
                       && (letter_off < CHAR_W'(LETTER_COUNT));

   // shared subtract/compare of the restoring remainder
   assign trial    = {rem_ff, rnd_ff[RND_W-1]};
   assign trial_ge = (trial >= {1'b0, count_ff});

   assign k_next   = k_ff + CNT_W'(1);
   assign pool_rd  = pool_ff[pool_ra];
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in     = state_ff;
      char_in      = char_ff;
      rnd_in       = rnd_ff;
      rem_in       = rem_ff;
      bit_cnt_in   = bit_cnt_ff;
      k_in         = k_ff;
      res_in       = res_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_char_in  = rsp_char_ff;
      map_we       = 1'b0;
      pool_we      = 1'b0;
      pool_wa      = k_ff[IDX_W-1:0];
      pool_ra      = k_next[IDX_W-1:0];
      req_stall    = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               char_in  = fold_upper(req_in_char);
               rnd_in   = req_random_value;
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            priority if (!is_letter) begin
               res_in   = char_ff;
               state_in = ST_REPLY;
            end else if (map_valid_ff[letter_idx]) begin
               res_in   = CHAR_A + CHAR_W'(map_idx_ff[letter_idx]);
               state_in = ST_REPLY;
            end else if (count_ff == '0) begin
               // empty pool: letter goes out as is, nothing changes
               res_in   = char_ff;
               state_in = ST_REPLY;
            end else begin
               rem_in     = '0;
               bit_cnt_in = BIT_CNT_W'(RND_W - 1);
               state_in   = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            rem_in     = trial_ge ? CNT_W'(trial - {1'b0, count_ff}) : trial[CNT_W-1:0];
            rnd_in     = {rnd_ff[RND_W-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff - BIT_CNT_W'(1);
            if (bit_cnt_ff == '0) begin
               state_in = ST_SELECT;
            end
         end
         ST_SELECT: begin
            pool_ra  = rem_ff[IDX_W-1:0];
            map_we   = 1'b1;
            res_in   = CHAR_A + CHAR_W'(pool_rd);
            k_in     = rem_ff;
            state_in = ST_SHIFT;
         end
         ST_SHIFT: begin
            if (k_next < count_ff) begin
               pool_we = 1'b1;   // pool[k] <= pool[k+1]
               k_in    = k_next;
            end else begin
               count_in = count_ff - CNT_W'(1);
               state_in = ST_REPLY;
            end
         end
         ST_REPLY: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= CNT_W'(LETTER_COUNT);
         map_valid_ff <= '0;
         for (int i = 0; i < LETTER_COUNT; i++) begin
            pool_ff[i] <= LETTER_W'(i);
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         if (map_we) begin
            map_valid_ff[letter_idx] <= 1'b1;
         end
         if (pool_we) begin
            pool_ff[pool_wa] <= pool_rd;
         end
      end
   end

   always_ff @(posedge clock) begin
      char_ff     <= char_in;
      rnd_ff      <= rnd_in;
      rem_ff      <= rem_in;
      bit_cnt_ff  <= bit_cnt_in;
      k_ff        <= k_in;
      res_ff      <= res_in;
      rsp_char_ff <= rsp_char_in;
      if (map_we) begin
         map_idx_ff[letter_idx] <= pool_rd;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_char = rsp_char_ff;

   // ---------------------------------------------------------------- assertions
   `ASSERT_ALWAYS(a_count_range, clock, reset, count_ff <= CNT_W'(LETTER_COUNT), "pool count above alphabet size")
   `ASSERT_ALWAYS(a_rem_below_count, clock, reset, (state_ff != ST_DIVIDE && state_ff != ST_SELECT) || rem_ff < count_ff, "remainder not below pool count")
   `ASSERT_ALWAYS(a_shift_ptr, clock, reset, state_ff != ST_SHIFT || k_ff < count_ff, "compaction pointer past pool end")
   `ASSERT_NEXT(a_accept_lookup, clock, reset, req_valid && !req_stall, state_ff == ST_LOOKUP, "accepted beat did not start lookup")
   `ASSERT_NEXT(a_count_step, clock, reset, state_ff == ST_SHIFT && k_next >= count_ff, count_ff == $past(count_ff) - CNT_W'(1), "pool count not decremented once")

endmodule
